### rtl/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// shared constants and types for the exhaustive tour search core
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int MAX_VERTICES = 12;
  localparam int VTX_W        = 4;
  localparam int WEIGHT_W     = 16;
  localparam int TOTAL_W      = 20;
  localparam int ADDR_W       = 8;
  localparam int DEPTH        = MAX_VERTICES * MAX_VERTICES;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RUN   = 1'b1;

  // request from the sequencer to the weight store
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WEIGHT_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

  // row-major address of a directed edge
  function automatic logic [ADDR_W-1:0] edge_addr(input logic [VTX_W-1:0] a,
                                                   input logic [VTX_W-1:0] b);
    logic [ADDR_W-1:0] r;
    r = ADDR_W'(a) * ADDR_W'(MAX_VERTICES) + ADDR_W'(b);
    return r;
  endfunction

endpackage

### rtl/tsp_weight_store.sv
// ----------------------------------------------------------------------------
// tsp_weight_store
// edge weight memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tsp_weight_store
  import tsp_pkg::*;
(
  input  logic                clk,
  input  store_req_t          req,
  output logic [WEIGHT_W-1:0] rd_data
);

  logic [WEIGHT_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[req.rd_addr];
  end

endmodule

### rtl/tsp_exhaustive_tour_search_core.sv
// ----------------------------------------------------------------------------
// tsp_exhaustive_tour_search_core
// brute force shortest closed tour search over a directed weight matrix
// ----------------------------------------------------------------------------
// usage:
//   in_ channel transactions either write one edge weight (in_tuser 0) or
//   start a search (in_tuser 1). cfg_wr_en/cfg_wr_data set the vertex count N.
//   a search fixes vertex 0 as start and walks all (N-1)! orders of the other
//   vertices in lexicographic order; per order one shared adder accumulates N
//   edge weights read one per cycle from the registered-read weight memory
//   after a setup step; the total is then compared with the best, and a
//   next-order step follows (scan, successor search, one swap per cycle in
//   the reversal).
//   writes can follow back to back.
//   results: N+1 out_ transactions (0, best order, 0), each with the best
//   total, tlast on the closing one, one per cycle while out_tready is high.
//   in_tready is low from a run's acceptance until its last result is taken;
//   a stalled out_tready holds the result.
//   reset (synchronous, rst_n low) sets N to 1 and idles the sequencer; the
//   weight memory is not cleared and must be written before use.
// ----------------------------------------------------------------------------
module tsp_exhaustive_tour_search_core
  import tsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,    // [3:0] vertex_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,       // [0] opcode
  input  logic [23:0] in_tdata,       // [3:0] from_vertex, [7:4] to_vertex,
                                      // [23:8] edge_weight
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,      // [3:0] tour_vertex, [23:4] tour_weight
  output logic        out_tlast
);

  localparam logic [3:0] S_IDLE = 4'd0, S_ADDR = 4'd1, S_ACC = 4'd2,
                         S_CMP = 4'd3, S_FINDI = 4'd4, S_FINDJ = 4'd5,
                         S_REV = 4'd6, S_EMIT = 4'd7, S_WAIT = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [VTX_W-1:0] vcount_r;
  logic [VTX_W-1:0] ord_r [MAX_VERTICES];
  logic [VTX_W-1:0] best_r [MAX_VERTICES];
  logic [TOTAL_W-1:0] best_total_r, sum_r;
  logic [VTX_W-1:0] n_r;          // N-1, number of permuted vertices
  logic [VTX_W-1:0] k_r;          // edge index in tour / emit index
  logic [VTX_W-1:0] prev_r;
  logic [VTX_W-1:0] i_r, j_r, lo_r, hi_r;
  logic             fin_r;        // last order reached, reversal finishes run
  logic             pend_r;       // read data arrives next cycle
  logic [WEIGHT_W-1:0] rd_data;
  store_req_t       req;
  logic [VTX_W-1:0] nxt_v;
  logic [3:0]       nv;

  assign in_tready = (state_r == S_IDLE);
  wire in_acc  = in_tvalid && in_tready;
  wire out_acc = out_tvalid && out_tready;

  // clamped vertex count
  always_comb begin
    nv = vcount_r;
    if (nv == 4'd0) nv = 4'd1;
    if (nv > 4'(MAX_VERTICES)) nv = 4'(MAX_VERTICES);
  end

  // next vertex of the tour being summed (0 closes the tour)
  assign nxt_v = (k_r < n_r) ? ord_r[k_r] : '0;

  // memory request
  always_comb begin
    req.wr_en   = in_acc && (in_tuser == OP_WRITE) &&
                  (in_tdata[3:0] < 4'(MAX_VERTICES)) &&
                  (in_tdata[7:4] < 4'(MAX_VERTICES));
    req.wr_addr = edge_addr(in_tdata[3:0], in_tdata[7:4]);
    req.wr_data = in_tdata[23:8];
    req.rd_addr = edge_addr(prev_r, nxt_v);
  end

  tsp_weight_store u_store (.clk(clk), .req(req), .rd_data(rd_data));

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 4'd1;
    end else if (cfg_wr_en) begin
      vcount_r <= cfg_wr_data[3:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_tvalid <= 1'b0;
      pend_r     <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_tuser == OP_RUN) begin
            for (int m = 0; m < MAX_VERTICES; m++) ord_r[m] <= 4'(m + 1);
            n_r          <= nv - 4'd1;
            best_total_r <= '1;
            state_r      <= S_ADDR;
          end
        end
        S_ADDR: begin
          // start summing one tour
          prev_r  <= '0;
          k_r     <= '0;
          sum_r   <= '0;
          pend_r  <= 1'b0;
          state_r <= S_ACC;
        end
        S_ACC: begin
          // one edge read per cycle, shared adder accumulates the delayed data
          if (pend_r) sum_r <= sum_r + TOTAL_W'(rd_data);
          if (k_r <= n_r) begin
            pend_r <= 1'b1;
            prev_r <= nxt_v;
            k_r    <= k_r + 4'd1;
          end else begin
            pend_r  <= 1'b0;
            if (!pend_r) state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (sum_r < best_total_r) begin
            best_total_r <= sum_r;
            for (int m = 0; m < MAX_VERTICES; m++) best_r[m] <= ord_r[m];
          end
          if (n_r < 4'd2) begin
            k_r <= '0; out_tvalid <= 1'b1; state_r <= S_EMIT;
          end else begin
            i_r <= n_r - 4'd2; state_r <= S_FINDI;
          end
        end
        S_FINDI: begin
          // scan for the rightmost ascent
          if (ord_r[i_r] < ord_r[i_r + 4'd1]) begin
            j_r <= n_r - 4'd1; state_r <= S_FINDJ;
          end else if (i_r == 4'd0) begin
            fin_r <= 1'b1; lo_r <= '0; hi_r <= n_r - 4'd1; state_r <= S_REV;
          end else begin
            i_r <= i_r - 4'd1;
          end
        end
        S_FINDJ: begin
          if (ord_r[j_r] > ord_r[i_r]) begin
            ord_r[i_r] <= ord_r[j_r];
            ord_r[j_r] <= ord_r[i_r];
            fin_r <= 1'b0; lo_r <= i_r + 4'd1; hi_r <= n_r - 4'd1;
            state_r <= S_REV;
          end else begin
            j_r <= j_r - 4'd1;
          end
        end
        S_REV: begin
          // one swap per cycle
          if (lo_r < hi_r) begin
            ord_r[lo_r] <= ord_r[hi_r];
            ord_r[hi_r] <= ord_r[lo_r];
            lo_r <= lo_r + 4'd1;
            hi_r <= hi_r - 4'd1;
          end else if (fin_r) begin
            k_r <= '0; out_tvalid <= 1'b1; state_r <= S_EMIT;
          end else begin
            state_r <= S_ADDR;
          end
        end
        S_EMIT: begin
          if (out_acc) begin
            if (k_r > n_r) begin
              out_tvalid <= 1'b0; state_r <= S_IDLE;
            end else begin
              k_r <= k_r + 4'd1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result payload from the emit index
  always_comb begin
    out_tdata[3:0] = '0;
    if (k_r != 4'd0 && k_r <= n_r) out_tdata[3:0] = best_r[k_r - 4'd1];
    out_tdata[23:4] = best_total_r;
    out_tlast = (k_r > n_r);
  end

endmodule

### rtl/tsp_checker.sv
// ----------------------------------------------------------------------------
// tsp_checker
// port level checks for the exhaustive tour search core
// ----------------------------------------------------------------------------
module tsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no input taken while results pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready during result burst");

  // closing result carries vertex 0
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[3:0] == 4'd0)
    else $error("tour does not close at vertex 0");

  // after last result the block is ready again
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready && !out_tvalid)
    else $error("block not idle after tour");

endmodule

bind tsp_exhaustive_tour_search_core tsp_checker u_tsp_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);

### tb/sv/tsp_tour_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_tour_checker
// watches the edge-load/search channel and the tour result channel, keeps a
// shadow weight matrix and vertex count, searches all tours itself on every
// run transaction and compares each result transaction with the oldest
// expected tour step
// ----------------------------------------------------------------------------
module tsp_tour_checker
  import tsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic        in_tuser,
  input  logic [23:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tlast,
  output int          errors,
  output int          steps_due
);

  typedef struct packed {
    logic [VTX_W-1:0]   vertex;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } tour_step_t;

  logic [WEIGHT_W-1:0] shadow_weights [MAX_VERTICES][MAX_VERTICES];
  logic [3:0]          shadow_count;
  tour_step_t          tour_steps_q [$];

  // exhaustive search in lexicographic order, first strictly smaller total wins
  function automatic void search_best_tour(input int n_vtx);
    int seq [MAX_VERTICES];
    int best_seq [MAX_VERTICES];
    int m, i, j, lo, hi, prev, tmp;
    logic [TOTAL_W-1:0] sum, best;
    bit more;
    tour_step_t step;
    m = n_vtx - 1;
    for (i = 0; i < MAX_VERTICES; i++) begin
      seq[i] = i + 1;
      best_seq[i] = 0;
    end
    best = '1;
    do begin
      prev = 0;
      sum = '0;
      for (i = 0; i < m; i++) begin
        sum += TOTAL_W'(shadow_weights[prev][seq[i]]);
        prev = seq[i];
      end
      sum += TOTAL_W'(shadow_weights[prev][0]);
      if (sum < best) begin
        best = sum;
        for (i = 0; i < m; i++) best_seq[i] = seq[i];
      end
      // next lexicographic order of the free vertices
      i = m - 2;
      while (i >= 0 && seq[i] >= seq[i+1]) i--;
      more = (i >= 0);
      if (more) begin
        j = m - 1;
        while (seq[j] <= seq[i]) j--;
        tmp = seq[i]; seq[i] = seq[j]; seq[j] = tmp;
        lo = i + 1;
        hi = m - 1;
        while (lo < hi) begin
          tmp = seq[lo]; seq[lo] = seq[hi]; seq[hi] = tmp;
          lo++;
          hi--;
        end
      end
    end while (more);
    step = '{vertex: '0, total: best, last: 1'b0};
    tour_steps_q = {tour_steps_q, step};
    for (i = 0; i < m; i++) begin
      step.vertex = VTX_W'(best_seq[i]);
      tour_steps_q = {tour_steps_q, step};
    end
    step.vertex = '0;
    step.last = 1'b1;
    tour_steps_q = {tour_steps_q, step};
  endfunction

  always @(posedge clk) begin
    int n_vtx;
    tour_step_t got, want;
    if (!rst_n) begin
      shadow_count = 4'd1;
      tour_steps_q.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en)
        shadow_count = cfg_wr_data[3:0];
      // input transaction: edge write or search start
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_WRITE) begin
          if (in_tdata[3:0] < MAX_VERTICES && in_tdata[7:4] < MAX_VERTICES)
            shadow_weights[in_tdata[3:0]][in_tdata[7:4]] = in_tdata[23:8];
        end else begin
          n_vtx = shadow_count;
          if (n_vtx < 1) n_vtx = 1;
          if (n_vtx > MAX_VERTICES) n_vtx = MAX_VERTICES;
          search_best_tour(n_vtx);
        end
      end
      // result transaction
      if (out_tvalid && out_tready) begin
        got = '{vertex: out_tdata[3:0], total: out_tdata[23:4], last: out_tlast};
        if (tour_steps_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result vertex=%0d total=%0d last=%0b",
                   $time, got.vertex, got.total, got.last);
        end else begin
          want = tour_steps_q.pop_front();
          if (got.vertex !== want.vertex) begin
            errors++;
            $display("%0t: tour_vertex expected %0d actual %0d",
                     $time, want.vertex, got.vertex);
          end
          if (got.total !== want.total) begin
            errors++;
            $display("%0t: tour_weight expected %0d actual %0d",
                     $time, want.total, got.total);
          end
          if (got.last !== want.last) begin
            errors++;
            $display("%0t: last expected %0b actual %0b",
                     $time, want.last, got.last);
          end
        end
      end
    end
    steps_due = tour_steps_q.size();
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the exhaustive tour search core: loads edge
// weights, sets the vertex count between searches and starts runs with
// bursty input and a stalling result sink; checking lives in tsp_tour_checker
// ----------------------------------------------------------------------------
module testbench
  import tsp_pkg::*;
();

  localparam int CYCLE_LIMIT = 3_000_000;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic        in_tuser;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tlast;
  int          errors;
  int          steps_due;
  int          cycles;
  int          burst_left;
  int          weight_mode;
  bit          edge_loaded [MAX_VERTICES][MAX_VERTICES];

  tsp_exhaustive_tour_search_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  tsp_tour_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .errors     (errors),
    .steps_due  (steps_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // result sink: one long hold-off on the first result, then mixed stalls
  initial begin
    int hold, span;
    out_tready = 1'b0;
    @(posedge clk);
    while (!out_tvalid) @(posedge clk);
    for (hold = 0; hold < 400; hold++) @(negedge clk);
    forever begin
      span = $urandom_range(16, 96);
      if ($urandom_range(0, 2) == 0) begin
        repeat (span) @(negedge clk) out_tready <= 1'b1;
      end else begin
        repeat (span) @(negedge clk) out_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // one input transaction, then maybe a gap at the end of a burst
  task automatic send_item(input logic op, input logic [3:0] from_v,
                           input logic [3:0] to_v, input logic [15:0] w);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {w, to_v, from_v};
    do @(posedge clk); while (!in_tready);
    if (op == OP_WRITE && from_v < MAX_VERTICES && to_v < MAX_VERTICES)
      edge_loaded[from_v][to_v] = 1'b1;
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 30)
                                                : $urandom_range(1, 6);
    end
  endtask

  function automatic logic [15:0] pick_weight();
    case (weight_mode)
      0: pick_weight = 16'($urandom_range(0, 3));
      1: pick_weight = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom_range(0, 1));
      default: pick_weight = 16'($urandom);
    endcase
  endfunction

  // every edge a search of n vertices reads must hold a written weight
  task automatic load_missing_edges(input int n_vtx);
    for (int i = 0; i < n_vtx; i++)
      for (int j = 0; j < n_vtx; j++)
        if (!edge_loaded[i][j])
          send_item(OP_WRITE, 4'(i), 4'(j), pick_weight());
  endtask

  task automatic start_search();
    send_item(OP_RUN, 4'($urandom), 4'($urandom), 16'($urandom));
  endtask

  // vertex count change once every result has drained
  task automatic set_vertex_count(input logic [3:0] count);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (steps_due != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= {4'($urandom), count};
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int sizes [10] = '{3, 4, 5, 3, 6, 2, 7, 4, 8, 5};
    int n_vtx;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tuser    = 1'b0;
    in_tdata    = '0;
    burst_left  = 4;
    weight_mode = 2;
    foreach (edge_loaded[i, j]) edge_loaded[i][j] = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // single vertex from reset: tour is 0,0 over the self edge
    send_item(OP_WRITE, 4'd0, 4'd0, 16'hFFFF);
    start_search();
    // out-of-range edges are dropped, offered while the sink holds off
    send_item(OP_WRITE, 4'd15, 4'd15, 16'hFFFF);
    send_item(OP_WRITE, 4'd12, 4'd3, 16'h1234);
    send_item(OP_WRITE, 4'd3, 4'd12, 16'h4321);
    // count zero behaves as one vertex
    set_vertex_count(4'd0);
    send_item(OP_WRITE, 4'd0, 4'd0, 16'h0000);
    start_search();
    // top count saturates to twelve; a full twelve vertex search is far too
    // long to run, so the register is rewritten before the next search
    set_vertex_count(4'd15);
    set_vertex_count(4'd2);
    send_item(OP_WRITE, 4'd0, 4'd1, 16'hFFFF);
    send_item(OP_WRITE, 4'd1, 4'd0, 16'hFFFF);
    send_item(OP_WRITE, 4'd1, 4'd1, 16'h0000);
    start_search();
    // all-max three vertex tours, every order ties
    set_vertex_count(4'd3);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        send_item(OP_WRITE, 4'(i), 4'(j), 16'hFFFF);
    start_search();

    // random phases over several vertex counts
    foreach (sizes[p]) begin
      n_vtx = sizes[p];
      weight_mode = $urandom_range(0, 2);
      set_vertex_count(4'(n_vtx));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 4) == 0)
          send_item(OP_WRITE, 4'($urandom), 4'($urandom), pick_weight());
        else
          send_item(OP_WRITE, 4'($urandom_range(0, n_vtx - 1)),
                    4'($urandom_range(0, n_vtx - 1)), pick_weight());
      end
      load_missing_edges(n_vtx);
      start_search();
      // sometimes a second search after one to four weight rewrites when the count is cheap
      if (n_vtx <= 6 && $urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 4))
          send_item(OP_WRITE, 4'($urandom_range(0, n_vtx - 1)),
                    4'($urandom_range(0, n_vtx - 1)), pick_weight());
        start_search();
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (steps_due != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
rtl/tsp_pkg.sv
rtl/tsp_weight_store.sv
rtl/tsp_exhaustive_tour_search_core.sv
rtl/tsp_checker.sv
tb/sv/tsp_tour_checker.sv
tb/sv/testbench.sv
